// ===== rtl/core/lcctg_pkg.sv =====
// Shared types, constants and microcode store of the combined clock trigger generator.
package lcctg_pkg;

   // Field widths
   localparam int unsigned LANES   = 5;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned IVL_W   = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned PER_W   = IVL_W + 2;   // up to 4 * interval
   localparam int unsigned WAVES   = 6;           // distinct periods
   localparam int unsigned PC_W    = 5;
   localparam int unsigned CNT_W   = 4;           // 2 quotient bits per step, 16 steps

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_CLOCK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // floor(x/3) = (x * RECIP3) >> RECIP3_SH, exact for 16-bit x
   localparam logic [IVL_W-1:0] RECIP3    = 16'd43691;
   localparam int unsigned      RECIP3_SH = 17;

   // Microcode operations
   typedef enum logic [2:0] {
      OP_CALC,   // register interval / 3
      OP_LOAD,   // latch period, start remainder
      OP_ITER,   // two remainder bits per cycle, loops on itself
      OP_SAVE,   // turn remainder into a wave level
      OP_DONE    // build result word, wait for output slot
   } op_type;

   // Distinct periods; the value is also the wave bit index
   typedef enum logic [2:0] {
      PER_HALF    = 3'd0,   // I/2
      PER_QUARTER = 3'd1,   // I/4
      PER_DOUBLE  = 3'd2,   // 2I
      PER_QUAD    = 3'd3,   // 4I
      PER_THIRD   = 3'd4,   // I/3
      PER_SIXTH   = 3'd5    // I/6
   } per_type;

   typedef struct packed {
      op_type  op;
      per_type per;
   } ctl_type;

   localparam logic [PC_W-1:0] PC_DONE = 5'd19;

   // Program: CALC, then LOAD/ITER/SAVE for each period, then DONE
   function automatic ctl_type rom_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      w.op  = OP_DONE;
      w.per = PER_HALF;
      unique case (pc)
         5'd0:  begin w.op = OP_CALC; w.per = PER_HALF;    end
         5'd1:  begin w.op = OP_LOAD; w.per = PER_HALF;    end
         5'd2:  begin w.op = OP_ITER; w.per = PER_HALF;    end
         5'd3:  begin w.op = OP_SAVE; w.per = PER_HALF;    end
         5'd4:  begin w.op = OP_LOAD; w.per = PER_QUARTER; end
         5'd5:  begin w.op = OP_ITER; w.per = PER_QUARTER; end
         5'd6:  begin w.op = OP_SAVE; w.per = PER_QUARTER; end
         5'd7:  begin w.op = OP_LOAD; w.per = PER_DOUBLE;  end
         5'd8:  begin w.op = OP_ITER; w.per = PER_DOUBLE;  end
         5'd9:  begin w.op = OP_SAVE; w.per = PER_DOUBLE;  end
         5'd10: begin w.op = OP_LOAD; w.per = PER_QUAD;    end
         5'd11: begin w.op = OP_ITER; w.per = PER_QUAD;    end
         5'd12: begin w.op = OP_SAVE; w.per = PER_QUAD;    end
         5'd13: begin w.op = OP_LOAD; w.per = PER_THIRD;   end
         5'd14: begin w.op = OP_ITER; w.per = PER_THIRD;   end
         5'd15: begin w.op = OP_SAVE; w.per = PER_THIRD;   end
         5'd16: begin w.op = OP_LOAD; w.per = PER_SIXTH;   end
         5'd17: begin w.op = OP_ITER; w.per = PER_SIXTH;   end
         5'd18: begin w.op = OP_SAVE; w.per = PER_SIXTH;   end
         default: begin w.op = OP_DONE; w.per = PER_HALF;  end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/logic_combined_clock_trigger_gen_top.sv =====
// Combined clock trigger generator: microcoded sequencer with a shared remainder unit.
//
// Each request word is taken when the block is not busy. A clock-edge word runs the
// program: a step for interval/3, then six periods (I/2, I/4, 2I, 4I, I/3, I/6),
// each in the shared radix-4 remainder unit (load, 16 iterations, save), then a
// final step to form the response word. Tick and clear words skip to the final step.
// The response register frees the request side: a new word is accepted while the
// previous response is still stalled, and the sequencer then waits in its final
// step until the response slot is free.
module logic_combined_clock_trigger_gen_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_tempo_interval_ms,
   input  logic [31:0] req_time_ms,
   input  logic        req_swapped,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_trigger_a_mask,
   output logic [4:0]  rsp_trigger_b_mask,
   output logic [4:0]  rsp_level_a_mask,
   output logic [4:0]  rsp_level_b_mask
);

   // Control state
   logic                                busy_ff;
   logic [lcctg_pkg::PC_W-1:0]          pc_ff;
   logic [lcctg_pkg::CNT_W-1:0]         cnt_ff;
   // Latched request word
   logic [lcctg_pkg::KIND_W-1:0]        kind_ff;
   logic [lcctg_pkg::IVL_W-1:0]         ivl_ff;
   logic [lcctg_pkg::TIME_W-1:0]        now_ff;
   logic                                swap_ff;
   // Datapath
   logic [lcctg_pkg::IVL_W-1:0]         third_ff;
   logic [lcctg_pkg::PER_W-1:0]         per_ff;
   logic [lcctg_pkg::PER_W-1:0]         rem_ff;
   logic [lcctg_pkg::TIME_W-1:0]        div_ff;
   logic [lcctg_pkg::WAVES-1:0]         wave_ff;
   // History
   logic [lcctg_pkg::LANES-1:0]         last_a_ff;
   logic [lcctg_pkg::LANES-1:0]         last_b_ff;
   // Response register
   logic                                rsp_valid_ff;
   logic [lcctg_pkg::LANES-1:0]         trig_a_ff, trig_b_ff, lvl_a_ff, lvl_b_ff;

   lcctg_pkg::ctl_type                  ctl;
   logic [lcctg_pkg::PER_W-1:0]         per_in;
   logic [lcctg_pkg::IVL_W-1:0]         third_in;
   logic [lcctg_pkg::PER_W:0]           step1, step2;
   logic [lcctg_pkg::PER_W-1:0]         rem1, rem_in;
   logic                                wave_bit;
   logic [lcctg_pkg::LANES-1:0]         wa, wb, xr, nr, lvl_a, lvl_b;
   logic                                out_free;
   logic                                rsp_load;

   assign ctl       = lcctg_pkg::rom_word(pc_ff);
   // no words taken while busy or in reset
   assign req_stall = busy_ff || reset;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = busy_ff && (ctl.op == lcctg_pkg::OP_DONE) && out_free;

   // Interval / 3 by reciprocal multiply
   assign third_in = lcctg_pkg::IVL_W'((32'(ivl_ff) * 32'(lcctg_pkg::RECIP3))
                                       >> lcctg_pkg::RECIP3_SH);

   // Period select
   always_comb begin
      unique case (ctl.per)
         lcctg_pkg::PER_HALF:    per_in = lcctg_pkg::PER_W'(ivl_ff >> 1);
         lcctg_pkg::PER_QUARTER: per_in = lcctg_pkg::PER_W'(ivl_ff >> 2);
         lcctg_pkg::PER_DOUBLE:  per_in = {1'b0, ivl_ff, 1'b0};
         lcctg_pkg::PER_QUAD:    per_in = {ivl_ff, 2'b00};
         lcctg_pkg::PER_THIRD:   per_in = lcctg_pkg::PER_W'(third_ff);
         lcctg_pkg::PER_SIXTH:   per_in = lcctg_pkg::PER_W'(third_ff >> 1);
         default:                per_in = '0;
      endcase
   end

   // Two restoring remainder steps per cycle, dividend bits from the top
   always_comb begin
      step1 = {rem_ff, div_ff[lcctg_pkg::TIME_W-1]};
      rem1  = (step1 >= {1'b0, per_ff}) ? lcctg_pkg::PER_W'(step1 - {1'b0, per_ff})
                                        : lcctg_pkg::PER_W'(step1);
      step2 = {rem1, div_ff[lcctg_pkg::TIME_W-2]};
      rem_in = (step2 >= {1'b0, per_ff}) ? lcctg_pkg::PER_W'(step2 - {1'b0, per_ff})
                                         : lcctg_pkg::PER_W'(step2);
   end

   // Wave is high in the first half of the period, or always for a zero period
   assign wave_bit = (per_ff == '0) || (rem_ff < (per_ff >> 1));

   // Lane k pairs: A uses I/2, I/4, 2I, 4I, I/3; B uses 2I, 4I, I/2, I/4, I/6
   assign wa = {wave_ff[lcctg_pkg::PER_THIRD], wave_ff[lcctg_pkg::PER_QUAD],
                wave_ff[lcctg_pkg::PER_DOUBLE], wave_ff[lcctg_pkg::PER_QUARTER],
                wave_ff[lcctg_pkg::PER_HALF]};
   assign wb = {wave_ff[lcctg_pkg::PER_SIXTH], wave_ff[lcctg_pkg::PER_QUARTER],
                wave_ff[lcctg_pkg::PER_HALF], wave_ff[lcctg_pkg::PER_QUAD],
                wave_ff[lcctg_pkg::PER_DOUBLE]};
   assign xr    = wa ^ wb;
   assign nr    = ~(wa | wb);
   assign lvl_a = swap_ff ? nr : xr;
   assign lvl_b = swap_ff ? xr : nr;

   // Sequencer, datapath and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         last_a_ff    <= '0;
         last_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (!busy_ff) begin
            if (req_valid) begin
               busy_ff <= 1'b1;
               kind_ff <= req_kind;
               ivl_ff  <= req_tempo_interval_ms;
               now_ff  <= req_time_ms;
               swap_ff <= req_swapped;
               pc_ff   <= (req_kind == lcctg_pkg::KIND_CLOCK) ? '0 : lcctg_pkg::PC_DONE;
            end
         end else begin
            unique case (ctl.op)
               lcctg_pkg::OP_CALC: begin
                  third_ff <= third_in;
                  pc_ff    <= pc_ff + 1'b1;
               end
               lcctg_pkg::OP_LOAD: begin
                  per_ff <= per_in;
                  rem_ff <= '0;
                  div_ff <= now_ff;
                  cnt_ff <= '1;
                  pc_ff  <= pc_ff + 1'b1;
               end
               lcctg_pkg::OP_ITER: begin
                  rem_ff <= rem_in;
                  div_ff <= {div_ff[lcctg_pkg::TIME_W-3:0], 2'b00};
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     pc_ff <= pc_ff + 1'b1;
                  end
               end
               lcctg_pkg::OP_SAVE: begin
                  wave_ff[ctl.per] <= wave_bit;
                  pc_ff            <= pc_ff + 1'b1;
               end
               lcctg_pkg::OP_DONE: begin
                  if (out_free) begin
                     busy_ff <= 1'b0;
                     priority if (kind_ff == lcctg_pkg::KIND_CLOCK) begin
                        trig_a_ff <= lvl_a & ~last_a_ff;
                        trig_b_ff <= lvl_b & ~last_b_ff;
                        lvl_a_ff  <= lvl_a;
                        lvl_b_ff  <= lvl_b;
                        last_a_ff <= lvl_a;
                        last_b_ff <= lvl_b;
                     end else if (kind_ff == lcctg_pkg::KIND_CLEAR) begin
                        trig_a_ff <= '0;
                        trig_b_ff <= '0;
                        lvl_a_ff  <= '0;
                        lvl_b_ff  <= '0;
                        last_a_ff <= '0;
                        last_b_ff <= '0;
                     end else begin
                        trig_a_ff <= '0;
                        trig_b_ff <= '0;
                        lvl_a_ff  <= last_a_ff;
                        lvl_b_ff  <= last_b_ff;
                     end
                  end
               end
               default: begin
                  pc_ff <= lcctg_pkg::PC_DONE;
               end
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger_a_mask = trig_a_ff;
   assign rsp_trigger_b_mask = trig_b_ff;
   assign rsp_level_a_mask   = lvl_a_ff;
   assign rsp_level_b_mask   = lvl_b_ff;

endmodule
